[hdl/pgw_pkg.sv]
// Shared types and constants for the two-level page walk.
// Holds operation codes, entry bit positions and the memory request structs.
// No dependencies.
package pgw_pkg;

  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned DirEntries = 1024;
  localparam int unsigned TabEntries = PageBytes / 4;
  localparam int unsigned DirAw      = $clog2(DirEntries);
  localparam int unsigned TabAw      = $clog2(TabEntries);
  localparam int unsigned PtAw       = DirAw + TabAw;
  localparam int unsigned OffW       = $clog2(PageBytes);
  localparam int unsigned BigOffW    = OffW + TabAw;

  localparam logic [1:0] OP_WR_DIR    = 2'd0;
  localparam logic [1:0] OP_WR_PT     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  localparam int unsigned BitPresent  = 0;
  localparam int unsigned BitPageSize = 7;

  typedef struct packed {
    logic              we;
    logic [DirAw-1:0]  waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [DirAw-1:0]  raddr;
  } pgw_dir_req_t;

  typedef struct packed {
    logic              we;
    logic [PtAw-1:0]   waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [PtAw-1:0]   raddr;
  } pgw_pt_req_t;

endpackage

[hdl/ia32_page_walk_translate.sv]
// Top level of the two-level page walk: command decode, walk sequencer, result register.
// Depends on pgw_pkg, pgw_dir_mem and pgw_pt_mem.
//
// channel   direction  handshake              payload
// command   in         start & !busy          operation_i, dir_index_i, table_index_i,
//                                             entry_data_i, linear_address_i
// result    out        valid_o, one cycle     physical_address_o, fault_o
//
// Writes complete in the accepting cycle and free the block at once.
// A translate reads the directory first; a directory fault or 4 MiB page
// goes from S_DIR straight to the result register, while a 4 KiB page needs the
// page-table read as well and goes through S_PT; the two memory reads are dependent.
// After reset busy stays high while the directory is swept to zero.
// The receiver cannot stall: valid_o marks each result for one cycle only.
module ia32_page_walk_translate import pgw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  dir_index_i,
  input  logic [9:0]  table_index_i,
  input  logic [31:0] entry_data_i,
  input  logic [31:0] linear_address_i,
  output logic        valid_o,
  output logic [31:0] physical_address_o,
  output logic        fault_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIR  = 2'd1;
  localparam logic [1:0] S_PT   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] lin_q, lin_d;
  logic        valid_q, valid_d;
  logic [31:0] phys_q, phys_d;
  logic        fault_q, fault_d;
  logic        clearing;
  logic        accept;
  logic [31:0] pde, pte;

  pgw_dir_req_t dir_req;
  pgw_pt_req_t  pt_req;

  pgw_dir_mem u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (dir_req),
    .rdata_o    (pde),
    .clearing_o (clearing)
  );

  pgw_pt_mem u_pt (
    .clk_i   (clk_i),
    .req_i   (pt_req),
    .rdata_o (pte)
  );

  assign busy   = clearing | (state_q != S_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    state_d = state_q;
    lin_d   = lin_q;
    valid_d = 1'b0;
    phys_d  = phys_q;
    fault_d = fault_q;

    dir_req.we    = accept & (operation_i == OP_WR_DIR);
    dir_req.waddr = dir_index_i;
    dir_req.wdata = entry_data_i;
    dir_req.re    = accept & (operation_i == OP_TRANSLATE);
    dir_req.raddr = linear_address_i[31 -: DirAw];

    pt_req.we    = accept & (operation_i == OP_WR_PT);
    pt_req.waddr = {dir_index_i, table_index_i};
    pt_req.wdata = entry_data_i;
    pt_req.re    = 1'b0;
    pt_req.raddr = lin_q[31 -: PtAw];

    unique case (state_q)
      S_IDLE: begin
        if (dir_req.re) begin
          lin_d   = linear_address_i;
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        if (!pde[BitPresent]) begin
          valid_d = 1'b1;
          phys_d  = 32'd0;
          fault_d = 1'b1;
          state_d = S_IDLE;
        end else if (pde[BitPageSize]) begin
          valid_d = 1'b1;
          phys_d  = {pde[31:BigOffW], lin_q[BigOffW-1:0]};
          fault_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          pt_req.re = 1'b1;
          state_d   = S_PT;
        end
      end
      S_PT: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (!pte[BitPresent]) begin
          phys_d  = 32'd0;
          fault_d = 1'b1;
        end else begin
          phys_d  = {pte[31:OffW], lin_q[OffW-1:0]};
          fault_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q   <= lin_d;
    phys_q  <= phys_d;
    fault_q <= fault_d;
  end

  assign valid_o            = valid_q;
  assign physical_address_o = phys_q;
  assign fault_o            = fault_q;

  a_translate_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == OP_TRANSLATE |=> state_q == S_DIR)
    else $error("translate did not start a directory read");

  a_pt_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PT |=> valid_o && state_q == S_IDLE)
    else $error("page-table read produced no result");

  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == S_IDLE && !clearing)
    else $error("result shown while a walk is in flight");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && fault_o |-> physical_address_o == 32'd0)
    else $error("faulting transaction carries an address");

  a_no_start_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> state_q == S_IDLE && !valid_o)
    else $error("walk active during directory sweep");

endmodule

[hdl/pgw_dir_mem.sv]
// Page-directory memory, 1024 x 32, registered read.
// Sweeps every entry to zero after reset. Depends on pgw_pkg.
module pgw_dir_mem import pgw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pgw_dir_req_t req_i,
  output logic [31:0]  rdata_o,
  output logic         clearing_o
);

  logic [31:0]      mem_q [DirEntries];
  logic [31:0]      rdata_q;
  logic             clr_q, clr_d;
  logic [DirAw-1:0] cnt_q, cnt_d;
  logic             we;
  logic [DirAw-1:0] waddr;
  logic [31:0]      wdata;

  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DirAw'(DirEntries - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // the sweep owns the write port until it is done
  assign we    = clr_q | req_i.we;
  assign waddr = clr_q ? cnt_q : req_i.waddr;
  assign wdata = clr_q ? 32'd0 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

[hdl/pgw_pt_mem.sv]
// Page-table memory, 1048576 (2**20) 32-bit entries, registered read.
// Contents are undefined until written. Depends on pgw_pkg.
module pgw_pt_mem import pgw_pkg::*; (
  input  logic        clk_i,
  input  pgw_pt_req_t req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [2**PtAw];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
